// ----- design/brb_pkg.sv -----
`default_nettype none
package brb_pkg;

	localparam int DEPTH      = 1024;
	localparam int READ_MAX   = 64;
	localparam int RESET_SIZE = 1024;

	localparam int DATA_W = 8;
	localparam int LEN_W  = 10;
	localparam int CFG_W  = 11;
	localparam int FILL_W = 10;
	localparam int ST_W   = 2;

	localparam int AW    = $clog2(DEPTH);
	localparam int SZ_W  = AW + 1;
	localparam int RC_W  = $clog2(READ_MAX + 1);
	localparam int CMP_A = (SZ_W > LEN_W) ? SZ_W : LEN_W;
	localparam int CMP_W = (CMP_A > CFG_W) ? CMP_A : CFG_W;

	localparam logic REQ_WR = 1'b0;
	localparam logic REQ_RD = 1'b1;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_DROP  = 2'd1;
	localparam logic [ST_W-1:0] ST_SHORT = 2'd2;
	localparam logic [ST_W-1:0] ST_BIG   = 2'd3;

	typedef struct packed {
		logic              we;
		logic [AW-1:0]     waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [AW-1:0]     raddr;
	} mem_req_t;

	typedef struct packed {
		logic            valid;
		logic            is_read;
		logic [ST_W-1:0] status;
		logic            last;
		logic [AW-1:0]   fill;
	} res_t;

	// usable positions: clamped ring size minus one
	function automatic logic [AW-1:0] cap_of(input logic [CFG_W-1:0] v);
		logic [CMP_W-1:0] s;
		s = CMP_W'(v);
		if (s < CMP_W'(2)) s = CMP_W'(2);
		if (s > CMP_W'(DEPTH)) s = CMP_W'(DEPTH);
		return AW'(s - CMP_W'(1));
	endfunction

endpackage
`default_nettype wire

// ----- design/brb_ram.sv -----
`default_nettype none
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/brb_ctrl.sv -----
`default_nettype none
module brb_ctrl
	import brb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              req_type,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic [LEN_W-1:0]  length,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output mem_req_t               mem_req,
	output res_t                   res
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RD   = 1'b1;

	logic             state_q, state_d;
	logic [AW-1:0]    cap_q, cap_d;
	logic [AW-1:0]    wr_idx_q, wr_idx_d;
	logic [AW-1:0]    rd_idx_q, rd_idx_d;
	logic [AW-1:0]    occ_q, occ_d;
	logic [LEN_W-1:0] brem_q, brem_d;
	logic             adm_q, adm_d;
	logic [RC_W-1:0]  rem_q, rem_d;

	logic             accept;
	logic [LEN_W-1:0] len_e;
	logic [AW-1:0]    free;
	logic             adm_v;
	logic [LEN_W-1:0] brem_v;
	logic             store;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx,
		input logic [AW-1:0] cap);
		logic [AW:0] n;
		n = {1'b0, idx} + (AW+1)'(1);
		return (n >= {1'b0, cap}) ? '0 : n[AW-1:0];
	endfunction

	assign busy      = (state_q == S_RD);
	// a pending request takes precedence over a size write
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign accept    = start && !busy;

	always_comb begin
		state_d  = state_q;
		cap_d    = cap_q;
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		occ_d    = occ_q;
		brem_d   = brem_q;
		adm_d    = adm_q;
		rem_d    = rem_q;
		mem_req  = '0;
		res      = '0;
		len_e    = (length == '0) ? LEN_W'(1) : length;
		free     = (occ_q < cap_q) ? (cap_q - occ_q) : '0;
		adm_v    = adm_q;
		brem_v   = brem_q;
		store    = 1'b0;

		if (cfg_valid && cfg_ready) begin
			cap_d    = cap_of(cfg_data);
			wr_idx_d = '0;
			rd_idx_d = '0;
			occ_d    = '0;
			brem_d   = '0;
			adm_d    = 1'b0;
		end else if (state_q == S_RD) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = rd_idx_q;
			rd_idx_d      = next_idx(rd_idx_q, cap_q);
			occ_d         = occ_q - AW'(1);
			rem_d         = rem_q - RC_W'(1);
			res.valid     = 1'b1;
			res.is_read   = 1'b1;
			res.status    = ST_OK;
			res.last      = (rem_q == RC_W'(1));
			res.fill      = occ_d;
			if (rem_q == RC_W'(1)) begin
				state_d = S_IDLE;
			end
		end else if (accept) begin
			res.valid = 1'b1;
			res.last  = 1'b1;
			res.fill  = occ_q;
			if (req_type == REQ_WR) begin
				if (brem_q == '0) begin
					adm_v  = CMP_W'(free) >= CMP_W'(len_e);
					brem_v = len_e - LEN_W'(1);
				end else begin
					brem_v = brem_q - LEN_W'(1);
				end
				store = adm_v && (occ_q < cap_q);
				if (store) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = wr_idx_q;
					mem_req.wdata = data_byte;
					wr_idx_d      = next_idx(wr_idx_q, cap_q);
					occ_d         = occ_q + AW'(1);
				end
				brem_d     = brem_v;
				adm_d      = (brem_v == '0) ? 1'b0 : adm_v;
				res.status = store ? ST_OK : ST_DROP;
				res.fill   = occ_d;
			end else if (CMP_W'(length) > CMP_W'(READ_MAX)) begin
				res.status = ST_BIG;
			end else if (CMP_W'(length) > CMP_W'(occ_q)) begin
				res.status = ST_SHORT;
			end else if (length == '0) begin
				res.status = ST_OK;
			end else begin
				// first byte goes out on the accepting cycle
				mem_req.re    = 1'b1;
				mem_req.raddr = rd_idx_q;
				rd_idx_d      = next_idx(rd_idx_q, cap_q);
				occ_d         = occ_q - AW'(1);
				res.is_read   = 1'b1;
				res.status    = ST_OK;
				res.last      = (length == LEN_W'(1));
				res.fill      = occ_d;
				if (length != LEN_W'(1)) begin
					rem_d   = RC_W'(length) - RC_W'(1);
					state_d = S_RD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= cap_of(CFG_W'(RESET_SIZE));
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			occ_q    <= '0;
			brem_q   <= '0;
			adm_q    <= 1'b0;
			rem_q    <= '0;
		end else begin
			state_q  <= state_d;
			cap_q    <= cap_d;
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			occ_q    <= occ_d;
			brem_q   <= brem_d;
			adm_q    <= adm_d;
			rem_q    <= rem_d;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_q)
		else $error("occupancy above ring capacity");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_idx_q < cap_q) && (rd_idx_q < cap_q))
		else $error("ring index out of range");

	a_rd_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (occ_q == $past(occ_q) - AW'(1)))
		else $error("read burst did not consume one byte");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("store read and written in one cycle");

endmodule
`default_nettype wire

// ----- design/byte_ring_buffer_burst.sv -----
// channel   direction  handshake               payload
// request   in         start & !busy           req_type, data_byte, length
// result    out        res_valid, one cycle    read_byte, status, last, fill_level
// config    in         cfg_valid & cfg_ready   cfg_data (ring size)
//
// a write byte or a refused read holds busy low
// a read of n bytes makes one store read port access per byte
// each result appears on the cycle after its store access or decision
// reset clears the ring state at once; the byte store needs no clearing
// results cannot be stalled; config is taken only while no read runs and start is low
`default_nettype none
module byte_ring_buffer_burst
	import brb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              req_type,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic [LEN_W-1:0]  length,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output logic                   res_valid,
	output logic [DATA_W-1:0]      read_byte,
	output logic [ST_W-1:0]        status,
	output logic                   last,
	output logic [FILL_W-1:0]      fill_level
);

	mem_req_t          mem_req;
	res_t              res;
	res_t              res_s1;
	logic [DATA_W-1:0] rdata;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.data_byte (data_byte),
		.length    (length),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mem_req   (mem_req),
		.res       (res)
	);

	brb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else begin
			res_s1 <= res;
		end
	end

	assign res_valid  = res_s1.valid;
	assign read_byte  = res_s1.is_read ? rdata : '0;
	assign status     = res_s1.status;
	assign last       = res_s1.last;
	assign fill_level = FILL_W'(res_s1.fill);

endmodule
`default_nettype wire
